// ===== src/ssfpg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfpg_pkg
// Shared types, constants and helpers for the scrolling starfield pixel
// generator: item codes, stream payload layout and star ROM geometry.
// ----------------------------------------------------------------------------
package ssfpg_pkg;

	// star rom geometry
	localparam int ROM_BYTES = 8192;
	localparam int ROM_AW    = $clog2(ROM_BYTES);
	localparam int ROM_DW    = 8;

	// default visible window
	localparam int DEF_VISIBLE_COLUMNS = 248;
	localparam int DEF_VISIBLE_ROWS    = 224;

	// pen and scroll constants
	localparam logic [7:0] PEN_FLOOR     = 8'hd0;
	localparam logic [7:0] SCROLL_FREEZE = 8'hff;
	localparam logic [7:0] LINE_OFFSET   = 8'd16;
	localparam logic [7:0] PEN_STEP      = 8'd2;
	localparam logic [8:0] STRIPE_OFFSET = 9'd8;

	// item kinds on the input tuser
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_LATCH = 2'd1,
		OP_PIXEL = 2'd2
	} op_t;

	// input tdata layout, lowest field last
	typedef struct packed {
		logic [1:0]        pad;
		logic [7:0]        row;
		logic [7:0]        column;
		logic              stars_off;
		logic [7:0]        background_color;
		logic [7:0]        vertical_scroll;
		logic [7:0]        star_y;
		logic [7:0]        star_x;
		logic [7:0]        rom_data;
		logic [ROM_AW-1:0] rom_address;
	} in_data_t;

	localparam int IN_DATA_W  = $bits(in_data_t);
	localparam int IN_USER_W  = $bits(op_t);
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 1;

	// raw rom byte index to bitmap byte index
	function automatic logic [ROM_AW-1:0] permute_address(input logic [ROM_AW-1:0] a);
		return {a[12:8], a[2:0], a[7:3]};
	endfunction

endpackage

// ===== src/ssfpg_ram.sv =====
// ----------------------------------------------------------------------------
// ssfpg_ram
// Generic single-port RAM, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module ssfpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== src/scrolling_starfield_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// scrolling_starfield_pixel_generator_core
// Starfield layer: star ROM load, per-frame scroll latch and per-pixel pen.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns a
// pixel result by way of the input register, star ROM read and result
// register; loads and frame latches take effect as they leave the input
// register and return nothing, as do pixels outside the visible window. The
// star ROM is a single-port 8192 x 8 memory that serves one load write or
// one pixel read per clock, which sets the rate of one item per clock. The
// pipeline is elastic: items are taken while a result waits until it fills.
module scrolling_starfield_pixel_generator_core
	import ssfpg_pkg::*;
#(
	parameter int VISIBLE_COLUMNS = DEF_VISIBLE_COLUMNS,
	parameter int VISIBLE_ROWS    = DEF_VISIBLE_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// rom_address, rom_data, star_x, star_y, vertical_scroll,
	// background_color, stars_off, column, row, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pen
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// is_star
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	localparam logic [8:0] COL_LIMIT = 9'(VISIBLE_COLUMNS);
	localparam logic [8:0] ROW_LIMIT = 9'(VISIBLE_ROWS);

	// input stage
	logic     valid_s1;
	in_data_t data_s1;
	op_t      op_s1;

	// rom read stage
	logic       valid_s2;
	logic [2:0] bit_sel_s2;
	logic [7:0] star_pen_s2;
	logic [7:0] sky_pen_s2;
	logic       disabled_s2;

	// result register
	logic       out_valid_q;
	logic [7:0] pen_q;
	logic       is_star_q;

	// frame state
	logic [7:0] scroll_x_q;
	logic [7:0] scroll_y_q;
	logic [7:0] prev_x_q;
	logic [7:0] prev_y_q;
	logic [7:0] sky_pen_q;
	logic [7:0] star_pen_q;
	logic       disabled_q;

	logic              advance_out;
	logic              advance_s1;
	logic              accept;
	logic              fire_s1;
	logic              is_load;
	logic              is_latch;
	logic              is_pixel;
	logic              visible;
	logic              pixel_go;
	logic [7:0]        pos_x;
	logic [7:0]        pos_y;
	logic [8:0]        stripe_sum;
	logic [7:0]        star_pen_pix;
	logic              ram_en;
	logic [ROM_AW-1:0] ram_addr;
	logic [ROM_DW-1:0] ram_rdata;
	logic              rom_bit;
	logic              star_hit;

	assign advance_out   = !out_valid_q || m_axis_tready;
	assign advance_s1    = !valid_s2 || advance_out;
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fire_s1       = valid_s1 && advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_data_t'(s_axis_tdata);
			op_s1   <= op_t'(s_axis_tuser);
		end
	end

	always_comb begin
		is_load  = 1'b0;
		is_latch = 1'b0;
		is_pixel = 1'b0;
		unique case (op_s1)
			OP_LOAD:  is_load  = 1'b1;
			OP_LATCH: is_latch = 1'b1;
			OP_PIXEL: is_pixel = 1'b1;
			default: ;
		endcase
	end

	assign visible  = ({1'b0, data_s1.column} < COL_LIMIT) && ({1'b0, data_s1.row} < ROW_LIMIT);
	assign pixel_go = is_pixel && visible;

	assign pos_x        = scroll_x_q + data_s1.column;
	assign pos_y        = scroll_y_q + data_s1.row + LINE_OFFSET;
	assign stripe_sum   = {1'b0, data_s1.column} + STRIPE_OFFSET;
	assign star_pen_pix = star_pen_q + PEN_STEP + {7'd0, stripe_sum[4]};

	assign ram_en   = fire_s1 && (is_load || pixel_go);
	assign ram_addr = is_load ? permute_address(data_s1.rom_address) : {pos_y, pos_x[7:3]};

	ssfpg_ram #(
		.WIDTH(ROM_DW),
		.DEPTH(ROM_BYTES)
	) u_star_rom (
		.clk  (clk),
		.en   (ram_en),
		.we   (is_load),
		.addr (ram_addr),
		.wdata(data_s1.rom_data),
		.rdata(ram_rdata)
	);

	// frame latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_x_q <= '0;
			scroll_y_q <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			sky_pen_q  <= '0;
			star_pen_q <= '0;
			disabled_q <= 1'b0;
		end else if (fire_s1 && is_latch) begin
			prev_x_q   <= data_s1.star_x;
			prev_y_q   <= data_s1.star_y;
			disabled_q <= data_s1.stars_off;
			if (data_s1.stars_off) begin
				scroll_x_q <= data_s1.star_x;
				scroll_y_q <= data_s1.star_y;
				sky_pen_q  <= data_s1.background_color;
				star_pen_q <= data_s1.background_color;
			end else begin
				scroll_x_q <= scroll_x_q + (data_s1.star_x - prev_x_q);
				if (data_s1.vertical_scroll != SCROLL_FREEZE) begin
					scroll_y_q <= scroll_y_q + (data_s1.star_y - prev_y_q);
				end
				if (data_s1.background_color < PEN_FLOOR) begin
					sky_pen_q  <= '0;
					star_pen_q <= PEN_FLOOR;
				end else begin
					sky_pen_q  <= data_s1.background_color;
					star_pen_q <= data_s1.background_color;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1 && pixel_go;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && pixel_go) begin
			bit_sel_s2  <= pos_x[2:0];
			star_pen_s2 <= star_pen_pix;
			sky_pen_s2  <= sky_pen_q;
			disabled_s2 <= disabled_q;
		end
	end

	assign rom_bit  = ram_rdata[bit_sel_s2];
	assign star_hit = !disabled_s2 && !rom_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_out && valid_s2) begin
			pen_q     <= star_hit ? star_pen_s2 : sky_pen_s2;
			is_star_q <= star_hit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pen_q;
	assign m_axis_tuser  = is_star_q;

endmodule

// ===== src/ssfpg_checker.sv =====
// ----------------------------------------------------------------------------
// ssfpg_checker
// Port-level checks for the starfield generator, bound to the top level.
// ----------------------------------------------------------------------------
module ssfpg_checker
	import ssfpg_pkg::*;
#(
	parameter int VISIBLE_COLUMNS = DEF_VISIBLE_COLUMNS,
	parameter int VISIBLE_ROWS    = DEF_VISIBLE_ROWS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic [IN_USER_W-1:0]  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	localparam logic [8:0] COL_LIMIT = 9'(VISIBLE_COLUMNS);
	localparam logic [8:0] ROW_LIMIT = 9'(VISIBLE_ROWS);

	in_data_t in_data;
	logic     pixel_in;

	assign in_data  = in_data_t'(s_axis_tdata);
	assign pixel_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PIXEL) &&
		({1'b0, in_data.column} < COL_LIMIT) && ({1'b0, in_data.row} < ROW_LIMIT);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// free-flowing output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked with output ready");

	// visible pixel comes out after the input and rom read stages when the output drains
	a_pixel_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_in ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("pixel result missing");

endmodule

bind scrolling_starfield_pixel_generator_core ssfpg_checker #(
	.VISIBLE_COLUMNS(VISIBLE_COLUMNS),
	.VISIBLE_ROWS   (VISIBLE_ROWS)
) u_ssfpg_checker (.*);

// ===== sim/scrolling_starfield_pixel_generator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrolling_starfield_pixel_generator_core_tb
// Streams star ROM loads, frame latches and pixel requests into the core,
// tracks scroll and pen state alongside it and checks every returned pen and
// star flag in order, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module scrolling_starfield_pixel_generator_core_tb;
	import ssfpg_pkg::*;

	localparam int VIS_COLS = DEF_VISIBLE_COLUMNS;
	localparam int VIS_ROWS = DEF_VISIBLE_ROWS;
	localparam int ITEM_TARGET = 650;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] last_x;
		logic [7:0] last_y;
		logic [7:0] sky_pen;
		logic [7:0] star_pen;
		logic       off;
	} star_view_t;

	typedef struct {
		logic [1:0] code;
		in_data_t   data;
	} stream_item_t;

	typedef struct {
		logic [7:0] pen;
		logic       is_star;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	in_data_t s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = OP_LOAD;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	stream_item_t item_backlog[$];
	pixel_result_t pen_expected_q[$];
	pixel_result_t want;
	stream_item_t next_item;

	star_view_t shown_view;
	star_view_t planned_view;
	logic [7:0] star_bitmap[ROM_BYTES];
	bit planned_written[ROM_BYTES];

	int items_queued = 0;
	int items_taken = 0;
	int mismatches = 0;
	int send_wait = 0;
	int recv_hold = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int row_band;
	int drain;

	scrolling_starfield_pixel_generator_core #(
		.VISIBLE_COLUMNS(VIS_COLS),
		.VISIBLE_ROWS   (VIS_ROWS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic logic [12:0] rom_slot(input logic [12:0] a);
		return (a & 13'h1f00) | ((a << 5) & 13'h00e0) | ((a >> 3) & 13'h001f);
	endfunction

	function automatic logic [12:0] raw_for_slot(input logic [12:0] p);
		return (p & 13'h1f00) | ((p & 13'h001f) << 3) | ((p >> 5) & 13'h0007);
	endfunction

	function automatic star_view_t latch_frame(input star_view_t s, input in_data_t d);
		star_view_t n;
		n = s;
		n.sky_pen = d.background_color;
		n.star_pen = d.background_color;
		n.off = d.stars_off;
		if (d.stars_off) begin
			n.scroll_x = d.star_x;
			n.scroll_y = d.star_y;
		end else begin
			if (d.background_color < PEN_FLOOR) begin
				n.star_pen = PEN_FLOOR;
				n.sky_pen = 8'h00;
			end
			n.scroll_x = s.scroll_x + 8'(d.star_x - s.last_x);
			if (d.vertical_scroll != SCROLL_FREEZE)
				n.scroll_y = s.scroll_y + 8'(d.star_y - s.last_y);
		end
		n.last_x = d.star_x;
		n.last_y = d.star_y;
		return n;
	endfunction

	function automatic logic [12:0] star_byte(input star_view_t s, input logic [7:0] col,
			input logic [7:0] row);
		logic [7:0] x;
		logic [7:0] y;
		x = s.scroll_x + col;
		y = s.scroll_y + row + LINE_OFFSET;
		return {y[7:0], x[7:3]};
	endfunction

	function automatic int pause_length();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	function automatic in_data_t random_payload();
		in_data_t p;
		p.pad = '0;
		p.row = 8'($urandom);
		p.column = 8'($urandom);
		p.stars_off = 1'($urandom);
		p.background_color = 8'($urandom);
		p.vertical_scroll = 8'($urandom);
		p.star_y = 8'($urandom);
		p.star_x = 8'($urandom);
		p.rom_data = 8'($urandom);
		p.rom_address = 13'($urandom);
		return p;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	task automatic push_item(input logic [1:0] code, input in_data_t d);
		stream_item_t it;
		it.code = code;
		it.data = d;
		item_backlog.push_back(it);
		items_queued++;
		if (code == OP_LOAD)
			planned_written[rom_slot(d.rom_address)] = 1'b1;
		else if (code == OP_LATCH)
			planned_view = latch_frame(planned_view, d);
	endtask

	task automatic queue_load(input logic [12:0] addr, input logic [7:0] data);
		in_data_t d;
		d = random_payload();
		d.rom_address = addr;
		d.rom_data = data;
		push_item(OP_LOAD, d);
	endtask

	task automatic queue_latch(input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] vs,
			input logic [7:0] bg, input logic off);
		in_data_t d;
		d = random_payload();
		d.star_x = sx;
		d.star_y = sy;
		d.vertical_scroll = vs;
		d.background_color = bg;
		d.stars_off = off;
		push_item(OP_LATCH, d);
	endtask

	// fill < 0 loads a random byte only where the bitmap byte is still blank
	task automatic queue_pixel(input int col, input int row, input int fill);
		in_data_t d;
		logic [12:0] slot;
		d = random_payload();
		d.column = 8'(col);
		d.row = 8'(row);
		slot = star_byte(planned_view, d.column, d.row);
		if (fill >= 0)
			queue_load(raw_for_slot(slot), 8'(fill));
		else if (!planned_written[slot])
			queue_load(raw_for_slot(slot), 8'($urandom_range(255)));
		push_item(OP_PIXEL, d);
	endtask

	task automatic track_starfield(input logic [1:0] code, input in_data_t d);
		pixel_result_t r;
		logic [7:0] x;
		logic [8:0] stripe;
		logic [7:0] bits;
		case (code)
			OP_LOAD: begin
				star_bitmap[rom_slot(d.rom_address)] = d.rom_data;
			end
			OP_LATCH: begin
				shown_view = latch_frame(shown_view, d);
			end
			OP_PIXEL: begin
				if (d.column < VIS_COLS && d.row < VIS_ROWS) begin
					r.pen = shown_view.sky_pen;
					r.is_star = 1'b0;
					if (!shown_view.off) begin
						x = shown_view.scroll_x + d.column;
						bits = star_bitmap[star_byte(shown_view, d.column, d.row)];
						if (!bits[x[2:0]]) begin
							stripe = {1'b0, d.column} + STRIPE_OFFSET;
							r.pen = shown_view.star_pen + PEN_STEP + {7'd0, stripe[4]};
							r.is_star = 1'b1;
						end
					end
					pen_expected_q.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= OP_LOAD;
			send_wait = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_starfield(s_axis_tuser, s_axis_tdata);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (item_backlog.size() > 0) begin
					next_item = item_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_item.data;
					s_axis_tuser <= next_item.code;
					if ($urandom_range(63) == 0)
						send_calm = !send_calm;
					send_wait = send_calm ? 0 : pause_length();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pen_expected_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected pixel result pen %02h is_star %0b",
						m_axis_tdata, m_axis_tuser[0]));
				end else begin
					want = pen_expected_q.pop_front();
					if (m_axis_tdata !== want.pen)
						flag_mismatch($sformatf("pen expected %02h actual %02h",
							want.pen, m_axis_tdata));
					if (m_axis_tuser[0] !== want.is_star)
						flag_mismatch($sformatf("is_star expected %0b actual %0b",
							want.is_star, m_axis_tuser[0]));
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(63) == 0)
					recv_calm = !recv_calm;
				recv_hold = recv_calm ? 0 : pause_length();
			end
		end
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int pick;
		int col;
		int row;
		logic [7:0] sx;
		logic [7:0] sy;
		logic [7:0] vs;
		logic [7:0] bg;
		shown_view = '{default: '0};
		planned_view = '{default: '0};

		// extremes, pens before any latch, window edges, unused code
		queue_load(13'h0000, 8'h00);
		queue_load(13'h1fff, 8'hff);
		queue_pixel(0, 0, -1);
		queue_pixel(VIS_COLS - 1, VIS_ROWS - 1, -1);
		queue_pixel(VIS_COLS, 0, -1);
		queue_pixel(0, VIS_ROWS, -1);
		queue_pixel(255, 255, -1);
		push_item(OP_UNUSED, random_payload());
		// dark background, both stripe phases and a sky pixel
		queue_latch(8'h10, 8'h20, 8'h00, 8'h00, 1'b0);
		queue_pixel(7, 5, 8'h00);
		queue_pixel(8, 5, 8'h00);
		queue_pixel(9, 5, 8'hff);
		// backward motion with vertical scroll frozen, floor boundary
		queue_latch(8'h08, 8'h18, SCROLL_FREEZE, 8'hcf, 1'b0);
		queue_pixel(100, 100, 8'h00);
		queue_latch(8'h08, 8'h18, 8'h12, PEN_FLOOR, 1'b0);
		queue_pixel(100, 100, 8'h00);
		// star pen wraps past 0xff
		queue_latch(8'hff, 8'hff, 8'h00, 8'hff, 1'b0);
		queue_pixel(0, 0, 8'h00);
		queue_pixel(8, 0, 8'h00);
		// starfield off, then back on from the resynced positions
		queue_latch(8'h55, 8'haa, 8'h00, 8'h6c, 1'b1);
		queue_pixel(30, 40, 8'h00);
		queue_pixel(250, 10, -1);
		queue_latch(8'h56, 8'ha9, SCROLL_FREEZE, 8'h00, 1'b0);
		queue_pixel(30, 40, -1);

		row_band = $urandom_range(VIS_ROWS - 16);
		while (items_queued < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				queue_load(13'($urandom_range(ROM_BYTES - 1)), 8'($urandom_range(255)));
			end else if (pick < 20) begin
				if ($urandom_range(9) < 7) begin
					sx = planned_view.last_x + 8'($urandom_range(16)) - 8'd8;
					sy = planned_view.last_y + 8'($urandom_range(16)) - 8'd8;
				end else begin
					sx = 8'($urandom);
					sy = 8'($urandom);
				end
				vs = ($urandom_range(4) == 0) ? SCROLL_FREEZE : 8'($urandom);
				bg = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 8'hd0)) : 8'($urandom);
				queue_latch(sx, sy, vs, bg, $urandom_range(9) == 0);
			end else if (pick < 22) begin
				push_item(OP_UNUSED, random_payload());
			end else begin
				if ($urandom_range(9) == 0) begin
					col = $urandom_range(255);
					row = $urandom_range(255, VIS_ROWS);
					if ($urandom_range(1)) begin
						col = $urandom_range(255, VIS_COLS);
						row = $urandom_range(255);
					end
				end else begin
					col = $urandom_range(VIS_COLS - 1);
					row = ($urandom_range(9) < 7) ? row_band + $urandom_range(15)
						: $urandom_range(VIS_ROWS - 1);
				end
				queue_pixel(col, row, -1);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < items_queued)
			@(negedge clk);
		for (drain = 0; drain < 2000 && pen_expected_q.size() != 0; drain++)
			@(negedge clk);
		if (pen_expected_q.size() != 0)
			flag_mismatch($sformatf("%0d pixel results never arrived", pen_expected_q.size()));
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
